// ===== rtl/lcdpt_pkg.sv =====
package lcdpt_pkg;

    // Display geometry handled by the block.
    localparam int PAGE_COUNT      = 8;
    localparam int GROUPS_PER_LINE = 16;

    // Field widths.
    localparam int PAGE_W  = 3;
    localparam int GROUP_W = 4;
    localparam int BYTE_W  = 8;
    localparam int LINES   = 8;

    // Bytes one request can cause, and the counter that walks them.
    localparam int MAX_PENDING = 11;
    localparam int IDX_W       = $clog2(MAX_PENDING);
    localparam int CNT_W       = $clog2(MAX_PENDING + 1);

    // Queue between intake and byte sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes.
    localparam logic OP_RENDER   = 1'b0;
    localparam logic OP_CONTRAST = 1'b1;

    // Controller command bytes.
    localparam logic [BYTE_W-1:0] CMD_PAGE_ADDR  = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_COL_LOW    = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_CONTRAST   = 8'h81;
    localparam int                POS_CMD_COUNT  = 3;
    localparam int                CONTRAST_COUNT = 2;

    // One classified job: the bytes to send, their RS flags and how many.
    typedef struct packed {
        logic [MAX_PENDING-1:0][BYTE_W-1:0] bytes;
        logic [MAX_PENDING-1:0]             is_data;
        logic [CNT_W-1:0]                   count;
    } t_job;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/lcdpt_ifs.sv =====
interface lcdpt_req_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [lcdpt_pkg::PAGE_W-1:0]        page_index;
    logic [lcdpt_pkg::GROUP_W-1:0]       column_group;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_0;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_1;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_2;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_3;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_4;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_5;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_6;
    logic [lcdpt_pkg::BYTE_W-1:0]        line_byte_7;
    logic [lcdpt_pkg::BYTE_W-1:0]        contrast_level;

    modport source (
        output valid, operation, page_index, column_group,
               line_byte_0, line_byte_1, line_byte_2, line_byte_3,
               line_byte_4, line_byte_5, line_byte_6, line_byte_7, contrast_level,
        input  ready
    );
    modport sink (
        input  valid, operation, page_index, column_group,
               line_byte_0, line_byte_1, line_byte_2, line_byte_3,
               line_byte_4, line_byte_5, line_byte_6, line_byte_7, contrast_level,
        output ready
    );
endinterface

interface lcdpt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lcdpt_pkg::BYTE_W-1:0] out_byte;
    logic                         is_data;
    logic                         last;

    modport source (output valid, out_byte, is_data, last, input ready);
    modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

// ===== rtl/lcdpt_front.sv =====
module lcdpt_front (
    lcdpt_req_if.sink          i_req,
    input  lcdpt_pkg::t_q_status i_q_status,
    output logic               o_push,
    output lcdpt_pkg::t_job    o_job
);

    logic [lcdpt_pkg::LINES-1:0][lcdpt_pkg::BYTE_W-1:0] lines;
    logic [lcdpt_pkg::LINES-1:0][lcdpt_pkg::BYTE_W-1:0] cols;
    logic                                               in_range;
    logic                                               keep;

    // A request is taken whenever the queue has room; dropped tiles just vanish.
    assign i_req.ready = !i_q_status.full;

    assign lines[0] = i_req.line_byte_0;
    assign lines[1] = i_req.line_byte_1;
    assign lines[2] = i_req.line_byte_2;
    assign lines[3] = i_req.line_byte_3;
    assign lines[4] = i_req.line_byte_4;
    assign lines[5] = i_req.line_byte_5;
    assign lines[6] = i_req.line_byte_6;
    assign lines[7] = i_req.line_byte_7;

    // Transpose the tile: column byte p takes bit p of every line.
    always_comb begin
        for (int p = 0; p < lcdpt_pkg::LINES; p++) begin
            for (int j = 0; j < lcdpt_pkg::LINES; j++) begin
                cols[p][j] = lines[j][p];
            end
        end
    end

    // Tiles outside the configured page and group range produce nothing.
    assign in_range =
        ({1'b0, i_req.page_index} < (lcdpt_pkg::PAGE_W + 1)'(lcdpt_pkg::PAGE_COUNT)) &&
        ({1'b0, i_req.column_group} <
         (lcdpt_pkg::GROUP_W + 1)'(lcdpt_pkg::GROUPS_PER_LINE));

    assign keep   = (i_req.operation == lcdpt_pkg::OP_CONTRAST) || in_range;
    assign o_push = i_req.valid && i_req.ready && keep;

    // Lay out the byte list of the job.
    always_comb begin
        o_job = '0;
        if (i_req.operation == lcdpt_pkg::OP_CONTRAST) begin
            o_job.bytes[0] = lcdpt_pkg::CMD_CONTRAST;
            o_job.bytes[1] = {2'b00, i_req.contrast_level[lcdpt_pkg::BYTE_W-1:2]};
            o_job.count    = lcdpt_pkg::CNT_W'(lcdpt_pkg::CONTRAST_COUNT);
        end else if (i_req.column_group == '0) begin
            o_job.bytes[0] = lcdpt_pkg::CMD_PAGE_ADDR |
                             lcdpt_pkg::BYTE_W'(i_req.page_index);
            o_job.bytes[1] = lcdpt_pkg::CMD_COL_HIGH;
            o_job.bytes[2] = lcdpt_pkg::CMD_COL_LOW;
            for (int p = 0; p < lcdpt_pkg::LINES; p++) begin
                o_job.bytes[lcdpt_pkg::POS_CMD_COUNT + p]   = cols[p];
                o_job.is_data[lcdpt_pkg::POS_CMD_COUNT + p] = 1'b1;
            end
            o_job.count = lcdpt_pkg::CNT_W'(lcdpt_pkg::POS_CMD_COUNT + lcdpt_pkg::LINES);
        end else begin
            for (int p = 0; p < lcdpt_pkg::LINES; p++) begin
                o_job.bytes[p]   = cols[p];
                o_job.is_data[p] = 1'b1;
            end
            o_job.count = lcdpt_pkg::CNT_W'(lcdpt_pkg::LINES);
        end
    end

endmodule

// ===== rtl/lcdpt_fifo.sv =====
module lcdpt_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lcdpt_pkg::t_job      i_job,
    input  logic                 i_pop,
    output lcdpt_pkg::t_job      o_job,
    output lcdpt_pkg::t_q_status o_status
);

    lcdpt_pkg::t_job                  r_mem [lcdpt_pkg::QUEUE_DEPTH];
    logic [lcdpt_pkg::QPTR_W-1:0]     r_wr, n_wr;
    logic [lcdpt_pkg::QPTR_W-1:0]     r_rd, n_rd;
    logic [lcdpt_pkg::QCNT_W-1:0]     r_cnt, n_cnt;

    assign o_status.full  = (r_cnt == lcdpt_pkg::QCNT_W'(lcdpt_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_job          = r_mem[r_rd];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == lcdpt_pkg::QPTR_W'(lcdpt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == lcdpt_pkg::QPTR_W'(lcdpt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/lcdpt_back.sv =====
module lcdpt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcdpt_pkg::t_job      i_job,
    input  lcdpt_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    lcdpt_rsp_if.source          o_rsp
);

    logic [lcdpt_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                         r_valid;
    logic [lcdpt_pkg::BYTE_W-1:0] r_byte;
    logic                         r_is_data;
    logic                         r_last;
    logic                         load;
    logic                         is_last;

    // The output register takes a new byte when a job is queued and the register is empty or being drained.
    assign load    = !i_q_status.empty && (!r_valid || o_rsp.ready);
    assign is_last = (lcdpt_pkg::CNT_W'(r_idx) + 1'b1 == i_job.count);
    assign o_pop   = load && is_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= i_job.bytes[r_idx];
            r_is_data <= i_job.is_data[r_idx];
            r_last    <= is_last;
        end
    end

    assign o_rsp.valid    = r_valid;
    assign o_rsp.out_byte = r_byte;
    assign o_rsp.is_data  = r_is_data;
    assign o_rsp.last     = r_last;

    // The byte counter rests at zero between jobs.
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.empty |-> r_idx == '0)
        else $error("byte index not at zero with queue empty");

    // The byte counter never runs past the job length.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> (lcdpt_pkg::CNT_W'(r_idx) < i_job.count))
        else $error("byte index beyond job length");

    // Loading the final byte of a job leaves a flagged last byte behind.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid && r_last && r_idx == '0)
        else $error("job finished without last flag");

endmodule

// ===== rtl/lcd_page_tile_transposer_core.sv =====
// LCD page tile transposer.
// Requests arrive on i_req: a render request carries one 8x8 tile (eight
// line bytes of a column group within a page), a contrast request carries a
// contrast level. Bytes for the display controller leave on o_rsp, one per
// transfer, with is_data giving the RS level and last marking the final
// byte of each request. Both channels use a valid/ready handshake.
// A render request at column group zero yields three positioning commands
// and eight data bytes, other groups yield eight data bytes, and a contrast
// request yields two command bytes. Tiles outside the page or group range
// are taken and produce nothing.
// An accepted request is written to the job queue; once the sequencer is
// free it loads the first byte into the output register. The output sends
// one byte per cycle while the receiver is ready, from the single byte-wide
// output register. A two-entry job queue lets requests be taken while earlier
// ones are still being sent; i_req.ready drops only when that queue is full.
// When the receiver stalls, the held byte stays put and the queue fills.
// Synchronous reset empties the queue and the output register.
module lcd_page_tile_transposer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdpt_req_if.sink   i_req,
    lcdpt_rsp_if.source o_rsp
);

    logic                 push;
    logic                 pop;
    lcdpt_pkg::t_job      push_job;
    lcdpt_pkg::t_job      head_job;
    lcdpt_pkg::t_q_status q_status;

    // Intake and classification.
    lcdpt_front u_front (
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Job queue.
    lcdpt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // Byte sequencer.
    lcdpt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_rsp      (o_rsp)
    );

endmodule

// ===== verif/tb_lcd_page_tile_transposer_core.sv =====
`timescale 1ns / 100ps

module tb_lcd_page_tile_transposer_core;

    localparam int RANDOM_ITEMS     = 460;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int HOLD_AT_ITEM     = 120;
    localparam int QUIET_FROM_ITEM  = 200;
    localparam int QUIET_TO_ITEM    = 260;
    localparam int PAUSE_AT_ITEM    = 320;

    // One request as seen on the input channel.
    typedef struct packed {
        logic                                               operation;
        logic [lcdpt_pkg::PAGE_W-1:0]                       page_index;
        logic [lcdpt_pkg::GROUP_W-1:0]                      column_group;
        logic [lcdpt_pkg::LINES-1:0][lcdpt_pkg::BYTE_W-1:0] lines;
        logic [lcdpt_pkg::BYTE_W-1:0]                       contrast_level;
    } t_tile_req;

    // One byte for the display controller.
    typedef struct packed {
        logic [lcdpt_pkg::BYTE_W-1:0] value;
        logic                         is_data;
        logic                         last;
    } t_lcd_byte;

    // Holds the controller bytes still owed and checks each one that arrives.
    class byte_scoreboard;
        t_lcd_byte expected_bytes[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Works out the controller bytes that one accepted request causes.
        function void note_request(t_tile_req r);
            t_lcd_byte                    seq[$];
            logic [lcdpt_pkg::BYTE_W-1:0] column;
            int                           p;
            int                           j;
            if (r.operation == lcdpt_pkg::OP_CONTRAST) begin
                seq.push_back('{lcdpt_pkg::CMD_CONTRAST, 1'b0, 1'b0});
                seq.push_back('{r.contrast_level >> 2, 1'b0, 1'b0});
            end else if (int'(r.page_index) < lcdpt_pkg::PAGE_COUNT &&
                         int'(r.column_group) < lcdpt_pkg::GROUPS_PER_LINE) begin
                // Column group zero first moves the controller to the page start.
                if (r.column_group == '0) begin
                    seq.push_back('{lcdpt_pkg::CMD_PAGE_ADDR |
                                    lcdpt_pkg::BYTE_W'(r.page_index), 1'b0, 1'b0});
                    seq.push_back('{lcdpt_pkg::CMD_COL_HIGH, 1'b0, 1'b0});
                    seq.push_back('{lcdpt_pkg::CMD_COL_LOW, 1'b0, 1'b0});
                end
                // Data byte p collects bit p of every line, line j into bit j.
                for (p = 0; p < lcdpt_pkg::BYTE_W; p++) begin
                    for (j = 0; j < lcdpt_pkg::LINES; j++) begin
                        column[j] = r.lines[j][p];
                    end
                    seq.push_back('{column, 1'b1, 1'b0});
                end
            end
            if (seq.size() > 0) begin
                seq[seq.size()-1].last = 1'b1;
            end
            foreach (seq[k]) begin
                expected_bytes.push_back(seq[k]);
            end
        endfunction

        // Compares an accepted byte with the oldest one owed.
        function void check_byte(t_lcd_byte got);
            t_lcd_byte want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h data %0b last %0b",
                         $time, got.value, got.is_data, got.last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.is_data !== want.is_data) begin
                $display("%0t: is_data mismatch, expected %0b, actual %0b",
                         $time, want.is_data, got.is_data);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcdpt_req_if req_if();
    lcdpt_rsp_if rsp_if();

    lcd_page_tile_transposer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    byte_scoreboard sb = new();

    int          items_sent = 0;
    bit          quiet      = 1'b0;
    bit          hold_output = 1'b0;
    int unsigned idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_tile_req random_req(logic op);
        t_tile_req r;
        int        j;
        r.operation      = op;
        r.page_index     = lcdpt_pkg::PAGE_W'($urandom_range(0, lcdpt_pkg::PAGE_COUNT - 1));
        r.column_group   =
            lcdpt_pkg::GROUP_W'($urandom_range(0, lcdpt_pkg::GROUPS_PER_LINE - 1));
        r.contrast_level = lcdpt_pkg::BYTE_W'($urandom_range(0, 255));
        for (j = 0; j < lcdpt_pkg::LINES; j++) begin
            r.lines[j] = lcdpt_pkg::BYTE_W'($urandom_range(0, 255));
        end
        return r;
    endfunction

    // Offers one request after an optional gap and waits until it is taken.
    task automatic send_request(input t_tile_req r);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.operation      <= r.operation;
        req_if.page_index     <= r.page_index;
        req_if.column_group   <= r.column_group;
        req_if.line_byte_0    <= r.lines[0];
        req_if.line_byte_1    <= r.lines[1];
        req_if.line_byte_2    <= r.lines[2];
        req_if.line_byte_3    <= r.lines[3];
        req_if.line_byte_4    <= r.lines[4];
        req_if.line_byte_5    <= r.lines[5];
        req_if.line_byte_6    <= r.lines[6];
        req_if.line_byte_7    <= r.lines[7];
        req_if.contrast_level <= r.contrast_level;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_tile(input int page, input int group,
                             input logic [lcdpt_pkg::LINES-1:0][lcdpt_pkg::BYTE_W-1:0] pattern);
        t_tile_req r;
        r              = random_req(lcdpt_pkg::OP_RENDER);
        r.page_index   = lcdpt_pkg::PAGE_W'(page);
        r.column_group = lcdpt_pkg::GROUP_W'(group);
        r.lines        = pattern;
        send_request(r);
    endtask

    task automatic send_contrast(input logic [lcdpt_pkg::BYTE_W-1:0] level);
        t_tile_req r;
        r                = random_req(lcdpt_pkg::OP_CONTRAST);
        r.contrast_level = level;
        send_request(r);
    endtask

    task automatic wait_until_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Reset and request stimulus.
    initial begin
        logic [lcdpt_pkg::LINES-1:0][lcdpt_pkg::BYTE_W-1:0] pattern;
        t_tile_req                                          r;
        int                                                 j;
        int                                                 mode;
        int                                                 page;
        int                                                 sweep_len;
        bit                                                 pause_done;

        pause_done            = 1'b0;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.operation     <= lcdpt_pkg::OP_RENDER;
        req_if.page_index    <= '0;
        req_if.column_group  <= '0;
        req_if.line_byte_0   <= '0;
        req_if.line_byte_1   <= '0;
        req_if.line_byte_2   <= '0;
        req_if.line_byte_3   <= '0;
        req_if.line_byte_4   <= '0;
        req_if.line_byte_5   <= '0;
        req_if.line_byte_6   <= '0;
        req_if.line_byte_7   <= '0;
        req_if.contrast_level <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Contrast extremes and the edges of the two-bit shift.
        send_contrast(8'h00);
        send_contrast(8'hFF);
        send_contrast(8'h03);
        send_contrast(8'h04);

        // Tile extremes: first and last page and group, all clear and all set.
        send_tile(0, 0, '0);
        send_tile(lcdpt_pkg::PAGE_COUNT - 1, lcdpt_pkg::GROUPS_PER_LINE - 1, '1);
        send_tile(lcdpt_pkg::PAGE_COUNT - 1, 0, '1);
        send_tile(0, lcdpt_pkg::GROUPS_PER_LINE - 1, '0);

        // Patterns that show the transpose direction.
        for (j = 0; j < lcdpt_pkg::LINES; j++) pattern[j] = lcdpt_pkg::BYTE_W'(1) << j;
        send_tile(3, 0, pattern);
        for (j = 0; j < lcdpt_pkg::LINES; j++) pattern[j] = ~(lcdpt_pkg::BYTE_W'(1) << j);
        send_tile(3, 1, pattern);
        for (j = 0; j < lcdpt_pkg::LINES; j++) pattern[j] = 8'h80 >> j;
        send_tile(5, 2, pattern);
        pattern    = '0;
        pattern[0] = 8'h01;
        send_tile(1, 0, pattern);
        pattern    = '0;
        pattern[7] = 8'h80;
        send_tile(2, 14, pattern);
        for (j = 0; j < lcdpt_pkg::LINES; j++) pattern[j] = j[0] ? 8'h55 : 8'hAA;
        send_tile(6, 0, pattern);

        // Fields that the operation ignores carry noise.
        r                = random_req(lcdpt_pkg::OP_CONTRAST);
        r.page_index     = '1;
        r.column_group   = '1;
        r.lines          = '1;
        send_request(r);
        r                = random_req(lcdpt_pkg::OP_RENDER);
        r.column_group   = '0;
        r.contrast_level = 8'hFF;
        send_request(r);
        r = random_req(lcdpt_pkg::OP_RENDER);
        send_tile(4, 8, r.lines);

        // Random part: mostly page sweeps from group zero, some contrast and stray tiles.
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= HOLD_AT_ITEM && items_sent < HOLD_AT_ITEM + 20) begin
                hold_output = 1'b1;
            end
            quiet = (items_sent >= QUIET_FROM_ITEM && items_sent < QUIET_TO_ITEM);
            if (!pause_done && items_sent >= PAUSE_AT_ITEM) begin
                pause_done    = 1'b1;
                req_if.valid <= 1'b0;
                wait_until_drained();
            end
            mode = $urandom_range(0, 99);
            if (mode < 65) begin
                page      = $urandom_range(0, lcdpt_pkg::PAGE_COUNT - 1);
                sweep_len = $urandom_range(1, lcdpt_pkg::GROUPS_PER_LINE);
                for (j = 0; j < sweep_len; j++) begin
                    r = random_req(lcdpt_pkg::OP_RENDER);
                    send_tile(page, j, r.lines);
                end
            end else if (mode < 80) begin
                send_request(random_req(lcdpt_pkg::OP_CONTRAST));
            end else begin
                send_request(random_req(lcdpt_pkg::OP_RENDER));
            end
        end
        req_if.valid <= 1'b0;
        quiet = 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Output back-pressure: random stalls, one long hold, none in the quiet stretch.
    initial begin
        int  stall_left;
        int  run_left;
        int  hold_left;
        bit  hold_taken;
        stall_left    = 0;
        run_left      = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_output && !hold_taken) begin
                hold_taken    = 1'b1;
                hold_left     = LONG_HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (quiet) begin
                rsp_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                rsp_if.ready <= 1'b1;
            end else begin
                run_left      = $urandom_range(0, 15);
                stall_left    = pick_gap();
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Both channels are sampled at the clock edge, requests before bytes.
    always @(posedge i_clk) begin
        t_tile_req req;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            req.operation      = req_if.operation;
            req.page_index     = req_if.page_index;
            req.column_group   = req_if.column_group;
            req.lines[0]       = req_if.line_byte_0;
            req.lines[1]       = req_if.line_byte_1;
            req.lines[2]       = req_if.line_byte_2;
            req.lines[3]       = req_if.line_byte_3;
            req.lines[4]       = req_if.line_byte_4;
            req.lines[5]       = req_if.line_byte_5;
            req.lines[6]       = req_if.line_byte_6;
            req.lines[7]       = req_if.line_byte_7;
            req.contrast_level = req_if.contrast_level;
            sb.note_request(req);
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_byte('{rsp_if.out_byte, rsp_if.is_data, rsp_if.last});
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
